/* sv/kehacc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kehacc_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 256;

    localparam int CELL_ID_W = 64;
    localparam int DEPOSIT_W = 24;
    localparam int ENERGY_W  = 32;
    localparam int SLOT_W    = 8;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MISS  = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } id_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic add_en;
        logic init_en;
    } energy_ctl_t;

endpackage

`default_nettype wire

/* sv/kehacc_id_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module kehacc_id_table #(
    parameter int TABLE_ENTRIES = kehacc_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire                               clk,
    input  wire kehacc_pkg::id_ctl_t          ctl,
    input  wire [IDX_W-1:0]                   addr,
    input  wire [kehacc_pkg::CELL_ID_W-1:0]   wr_data,
    input  wire [kehacc_pkg::CELL_ID_W-1:0]   key,
    output logic                              match
);

    logic [kehacc_pkg::CELL_ID_W-1:0] mem [TABLE_ENTRIES];
    logic [kehacc_pkg::CELL_ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign match = (rd_data_reg == key);

endmodule

`default_nettype wire

/* sv/kehacc_energy_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module kehacc_energy_store #(
    parameter int TABLE_ENTRIES = kehacc_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire                               clk,
    input  wire kehacc_pkg::energy_ctl_t      ctl,
    input  wire [IDX_W-1:0]                   addr,
    input  wire [kehacc_pkg::DEPOSIT_W-1:0]   deposit,
    output logic [kehacc_pkg::ENERGY_W-1:0]   sum
);

    localparam int EW = kehacc_pkg::ENERGY_W;

    logic [EW-1:0] mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_data_reg;
    logic [EW:0]   raw_sum;

    assign raw_sum = {1'b0, rd_data_reg} + (EW + 1)'(deposit);
    assign sum     = raw_sum[EW] ? {EW{1'b1}} : raw_sum[EW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.add_en)
        begin
            mem[addr] <= sum;
        end
        else if (ctl.init_en)
        begin
            mem[addr] <= EW'(deposit);
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

endmodule

`default_nettype wire

/* sv/keyed_energy_hit_accumulator_top.sv */
// A last-slot hit passes the check, add and output states; otherwise the filled slots
// are scanned; a hit goes to the add state and a miss to the miss state, which inserts
// the cell or, with the table full, drops the beat; an empty table goes straight there.
// One beat at a time: the next input beat is taken in the cycle after the result is
// registered, so the identifier memory scan and output stalls set the rate. Reset clears
// the fill count, last slot and handshake state at once; memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module keyed_energy_hit_accumulator_top #(
    parameter int TABLE_ENTRIES = kehacc_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire [kehacc_pkg::CELL_ID_W-1:0]   cell_id,
    input  wire [kehacc_pkg::DEPOSIT_W-1:0]   energy_deposit,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [kehacc_pkg::SLOT_W-1:0]     slot_index,
    output logic [kehacc_pkg::ENERGY_W-1:0]   total_energy,
    output logic                              created,
    output logic                              table_full
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int EXT_W = (IDX_W > kehacc_pkg::SLOT_W) ? IDX_W : kehacc_pkg::SLOT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    kehacc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] last_slot_reg, last_slot_next;
    logic [CNT_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    logic [kehacc_pkg::CELL_ID_W-1:0] key_reg, key_next;
    logic [kehacc_pkg::DEPOSIT_W-1:0] dep_reg, dep_next;

    logic [IDX_W-1:0]                res_slot_reg, res_slot_next;
    logic [kehacc_pkg::ENERGY_W-1:0] res_total_reg, res_total_next;
    logic                            res_created_reg, res_created_next;
    logic                            res_full_reg, res_full_next;

    logic                            out_valid_reg, out_valid_next;
    logic [kehacc_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [kehacc_pkg::ENERGY_W-1:0] out_total_reg, out_total_next;
    logic                            out_created_reg, out_created_next;
    logic                            out_full_reg, out_full_next;

    kehacc_pkg::id_ctl_t     id_ctl;
    kehacc_pkg::energy_ctl_t en_ctl;
    logic [IDX_W-1:0]        id_addr;
    logic [IDX_W-1:0]        en_addr;
    logic                    id_match;
    logic [kehacc_pkg::ENERGY_W-1:0] en_sum;
    logic                    in_beat;
    logic [EXT_W-1:0]        res_slot_ext;

    kehacc_id_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_id_table (
        .clk     (clk),
        .ctl     (id_ctl),
        .addr    (id_addr),
        .wr_data (key_reg),
        .key     (key_reg),
        .match   (id_match)
    );

    kehacc_energy_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_energy_store (
        .clk     (clk),
        .ctl     (en_ctl),
        .addr    (en_addr),
        .deposit (dep_reg),
        .sum     (en_sum)
    );

    assign in_stall     = (state_reg != kehacc_pkg::S_IDLE);
    assign in_beat      = in_valid && !in_stall;
    assign res_slot_ext = EXT_W'(res_slot_reg);

    assign out_valid    = out_valid_reg;
    assign slot_index   = out_slot_reg;
    assign total_energy = out_total_reg;
    assign created      = out_created_reg;
    assign table_full   = out_full_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        last_slot_next   = last_slot_reg;
        scan_ptr_next    = scan_ptr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        slot_next        = slot_reg;
        key_next         = key_reg;
        dep_next         = dep_reg;
        res_slot_next    = res_slot_reg;
        res_total_next   = res_total_reg;
        res_created_next = res_created_reg;
        res_full_next    = res_full_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_slot_next    = out_slot_reg;
        out_total_next   = out_total_reg;
        out_created_next = out_created_reg;
        out_full_next    = out_full_reg;
        id_ctl           = '0;
        en_ctl           = '0;
        id_addr          = last_slot_reg;
        en_addr          = slot_reg;

        case (state_reg)
            kehacc_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    key_next        = cell_id;
                    dep_next        = energy_deposit;
                    scan_ptr_next   = '0;
                    pend_valid_next = 1'b0;
                    if (CNT_W'(last_slot_reg) < count_reg)
                    begin
                        id_ctl.rd_en = 1'b1;
                        id_addr      = last_slot_reg;
                        state_next   = kehacc_pkg::S_CHECK;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = kehacc_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = kehacc_pkg::S_MISS;
                    end
                end
            end

            kehacc_pkg::S_CHECK:
            begin
                if (id_match)
                begin
                    slot_next     = last_slot_reg;
                    en_ctl.rd_en  = 1'b1;
                    en_addr       = last_slot_reg;
                    state_next    = kehacc_pkg::S_ADD;
                end
                else
                begin
                    state_next = kehacc_pkg::S_SCAN;
                end
            end

            kehacc_pkg::S_SCAN:
            begin
                if (pend_valid_reg && id_match)
                begin
                    slot_next      = pend_idx_reg;
                    last_slot_next = pend_idx_reg;
                    en_ctl.rd_en   = 1'b1;
                    en_addr        = pend_idx_reg;
                    state_next     = kehacc_pkg::S_ADD;
                end
                else if (pend_valid_reg && (CNT_W'(pend_idx_reg) == count_reg - 1'b1))
                begin
                    state_next = kehacc_pkg::S_MISS;
                end
                else
                begin
                    pend_valid_next = (scan_ptr_reg < count_reg);
                    pend_idx_next   = scan_ptr_reg[IDX_W-1:0];
                    id_ctl.rd_en    = (scan_ptr_reg < count_reg);
                    id_addr         = scan_ptr_reg[IDX_W-1:0];
                    scan_ptr_next   = scan_ptr_reg + 1'b1;
                end
            end

            kehacc_pkg::S_MISS:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    res_slot_next    = '0;
                    res_total_next   = '0;
                    res_created_next = 1'b0;
                    res_full_next    = 1'b1;
                end
                else
                begin
                    id_ctl.wr_en     = 1'b1;
                    id_addr          = count_reg[IDX_W-1:0];
                    en_ctl.init_en   = 1'b1;
                    en_addr          = count_reg[IDX_W-1:0];
                    last_slot_next   = count_reg[IDX_W-1:0];
                    count_next       = count_reg + 1'b1;
                    res_slot_next    = count_reg[IDX_W-1:0];
                    res_total_next   = kehacc_pkg::ENERGY_W'(dep_reg);
                    res_created_next = 1'b1;
                    res_full_next    = 1'b0;
                end
                state_next = kehacc_pkg::S_OUT;
            end

            kehacc_pkg::S_ADD:
            begin
                en_ctl.add_en    = 1'b1;
                en_addr          = slot_reg;
                res_slot_next    = slot_reg;
                res_total_next   = en_sum;
                res_created_next = 1'b0;
                res_full_next    = 1'b0;
                state_next       = kehacc_pkg::S_OUT;
            end

            kehacc_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_slot_next    = res_slot_ext[kehacc_pkg::SLOT_W-1:0];
                    out_total_next   = res_total_reg;
                    out_created_next = res_created_reg;
                    out_full_next    = res_full_reg;
                    state_next       = kehacc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kehacc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kehacc_pkg::S_IDLE;
            count_reg      <= '0;
            last_slot_reg  <= '0;
            scan_ptr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_slot_reg  <= last_slot_next;
            scan_ptr_reg   <= scan_ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        slot_reg        <= slot_next;
        key_reg         <= key_next;
        dep_reg         <= dep_next;
        res_slot_reg    <= res_slot_next;
        res_total_reg   <= res_total_next;
        res_created_reg <= res_created_next;
        res_full_reg    <= res_full_next;
        out_slot_reg    <= out_slot_next;
        out_total_reg   <= out_total_next;
        out_created_reg <= out_created_next;
        out_full_reg    <= out_full_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count exceeds table size");

    a_last_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(last_slot_reg) < count_reg))
        else $error("last slot points past the filled region");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kehacc_pkg::S_MISS && count_reg != FULL_COUNT)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the fill count");

    a_full_not_created: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_full_reg && out_created_reg))
        else $error("dropped beat reported as created");
`endif

endmodule

`default_nettype wire

/* verif/keyed_energy_hit_accumulator_checker.sv */
`timescale 1ns / 1ps

module keyed_energy_hit_accumulator_checker #(
    parameter int TABLE_ENTRIES = kehacc_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire                               in_stall,
    input  wire [kehacc_pkg::CELL_ID_W-1:0]   cell_id,
    input  wire [kehacc_pkg::DEPOSIT_W-1:0]   energy_deposit,
    input  wire                               out_valid,
    input  wire                               out_stall,
    input  wire [kehacc_pkg::SLOT_W-1:0]      slot_index,
    input  wire [kehacc_pkg::ENERGY_W-1:0]    total_energy,
    input  wire                               created,
    input  wire                               table_full,
    output int                                errors,
    output int                                outstanding
);

    typedef struct packed {
        logic [kehacc_pkg::SLOT_W-1:0]   slot;
        logic [kehacc_pkg::ENERGY_W-1:0] total;
        logic                            created;
        logic                            full;
    } hit_result_t;

    logic [kehacc_pkg::CELL_ID_W-1:0] stored_ids [TABLE_ENTRIES];
    logic [kehacc_pkg::ENERGY_W-1:0]  stored_totals [TABLE_ENTRIES];
    int                   fill_count;
    int                   cached_slot;
    hit_result_t          awaited_hits [$];
    int                   beats_in;
    int                   beats_out;
    int                   fail_total = 0;

    assign errors = fail_total;
    assign outstanding = beats_in - beats_out;

    function automatic hit_result_t accumulate_deposit(
        input logic [kehacc_pkg::CELL_ID_W-1:0] cid,
        input logic [kehacc_pkg::DEPOSIT_W-1:0] dep
    );
        hit_result_t                   res;
        int                            slot;
        logic [kehacc_pkg::ENERGY_W:0] sum;
        res = '0;
        slot = -1;
        if (cached_slot < fill_count && stored_ids[cached_slot] == cid)
            slot = cached_slot;
        for (int i = 0; slot < 0 && i < fill_count; i++)
        begin
            if (stored_ids[i] == cid)
            begin
                slot = i;
                cached_slot = i;
            end
        end
        if (slot < 0)
        begin
            if (fill_count >= TABLE_ENTRIES)
            begin
                res.full = 1'b1;
                return res;
            end
            slot = fill_count;
            stored_ids[slot] = cid;
            stored_totals[slot] = '0;
            fill_count++;
            cached_slot = slot;
            res.created = 1'b1;
        end
        sum = {1'b0, stored_totals[slot]} + dep;
        stored_totals[slot] = sum[kehacc_pkg::ENERGY_W] ? '1 :
                              sum[kehacc_pkg::ENERGY_W-1:0];
        res.slot = slot[kehacc_pkg::SLOT_W-1:0];
        res.total = stored_totals[slot];
        return res;
    endfunction

    task automatic flag_mismatch(input string why, input hit_result_t want);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t mismatch, %s: slot %0d/%0d total %0d/%0d created %0b/%0b full %0b/%0b",
                     $time, why, want.slot, slot_index, want.total, total_energy,
                     want.created, created, want.full, table_full);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t want;
        if (!rst_n)
        begin
            fill_count = 0;
            cached_slot = 0;
            awaited_hits.delete();
            beats_in <= 0;
            beats_out <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out <= beats_out + 1;
                if (awaited_hits.size() == 0)
                    flag_mismatch("unexpected beat (expected/actual)", '0);
                else
                begin
                    want = awaited_hits.pop_front();
                    if (slot_index !== want.slot || total_energy !== want.total ||
                        created !== want.created || table_full !== want.full)
                        flag_mismatch("expected/actual", want);
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_hits.push_back(accumulate_deposit(cell_id, energy_deposit));
                beats_in <= beats_in + 1;
            end
        end
    end

endmodule

/* verif/keyed_energy_hit_accumulator_top_test.sv */
`timescale 1ns / 1ps

module keyed_energy_hit_accumulator_top_test;

    localparam int TABLE_ENTRIES = kehacc_pkg::DEFAULT_TABLE_ENTRIES;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 40;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [kehacc_pkg::CELL_ID_W-1:0]    cell_id = '0;
    logic [kehacc_pkg::DEPOSIT_W-1:0]    energy_deposit = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [kehacc_pkg::SLOT_W-1:0]       slot_index;
    logic [kehacc_pkg::ENERGY_W-1:0]     total_energy;
    logic                                created;
    logic                                table_full;
    int                                  errors;
    int                                  outstanding;

    bit                                  hold_off_req = 1'b0;
    int                                  burst_left = 0;
    bit                                  seen_cells [logic [kehacc_pkg::CELL_ID_W-1:0]];
    logic [kehacc_pkg::CELL_ID_W-1:0]    table_cells [$];
    logic [kehacc_pkg::CELL_ID_W-1:0]    prev_cell = '0;

    keyed_energy_hit_accumulator_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_id       (cell_id),
        .energy_deposit(energy_deposit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .total_energy  (total_energy),
        .created       (created),
        .table_full    (table_full)
    );

    keyed_energy_hit_accumulator_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_id       (cell_id),
        .energy_deposit(energy_deposit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .total_energy  (total_energy),
        .created       (created),
        .table_full    (table_full),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always #6 clk = ~clk;

    function automatic logic [kehacc_pkg::CELL_ID_W-1:0] fresh_cell();
        logic [kehacc_pkg::CELL_ID_W-1:0] cid;
        cid = {$urandom, $urandom};
        while (seen_cells.exists(cid))
            cid = {$urandom, $urandom};
        return cid;
    endfunction

    function automatic logic [kehacc_pkg::DEPOSIT_W-1:0] random_deposit();
        logic [kehacc_pkg::DEPOSIT_W-1:0] dep;
        case ($urandom_range(0, 9))
            0: dep = '0;
            1: dep = '1;
            default: dep = $urandom;
        endcase
        return dep;
    endfunction

    task automatic send_deposit(input logic [kehacc_pkg::CELL_ID_W-1:0] cid,
                                input logic [kehacc_pkg::DEPOSIT_W-1:0] dep);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cell_id <= cid;
        energy_deposit <= dep;
        do @(posedge clk); while (in_stall);
        if (!seen_cells.exists(cid))
        begin
            seen_cells[cid] = 1'b1;
            if (table_cells.size() < TABLE_ENTRIES)
                table_cells.push_back(cid);
        end
        prev_cell = cid;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        int stall_pct;
        int run_len;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
            run_len = $urandom_range(5, 60);
            repeat (run_len)
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int                               pick;
        logic [kehacc_pkg::CELL_ID_W-1:0] cid;
        logic [kehacc_pkg::CELL_ID_W-1:0] hot_cell;
        logic [kehacc_pkg::CELL_ID_W-1:0] pool [$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The very first beat finds the cached slot beyond the fill count.
        send_deposit('0, '0);
        send_deposit('0, '1);
        send_deposit('1, '1);
        send_deposit('0, 24'd1);
        send_deposit('0, 24'd5);
        send_deposit('1, '0);
        send_deposit({1'b1, 63'b0}, 24'h800000);
        send_deposit(64'd1, 24'h000001);
        send_deposit({32{2'b01}}, {12{2'b01}});
        send_deposit({32{2'b10}}, {12{2'b10}});
        send_deposit({32{2'b01}}, '1);
        send_deposit('1, 24'h7FFFFF);
        send_deposit(64'd1, '0);
        send_deposit({1'b1, 63'b0}, 24'h7FFFFF);

        pool = table_cells;
        for (int i = 0; i < 30; i++)
            pool.push_back(fresh_cell());
        hot_cell = fresh_cell();
        pool.push_back(hot_cell);

        // A hot cell takes full-scale beats often enough to saturate its total.
        for (int n = 0; n < 1300; n++)
        begin
            if (n == 200)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_deposit(hot_cell, '1);
            else if (pick < 50)
                send_deposit(prev_cell, random_deposit());
            else if (pick < 95)
                send_deposit(pool[$urandom_range(0, pool.size() - 1)], random_deposit());
            else
            begin
                cid = fresh_cell();
                pool.push_back(cid);
                send_deposit(cid, random_deposit());
            end
        end

        drain_results();

        while (table_cells.size() < TABLE_ENTRIES)
        begin
            if ($urandom_range(0, 99) < 60)
                send_deposit(fresh_cell(), random_deposit());
            else
                send_deposit(table_cells[$urandom_range(0, table_cells.size() - 1)],
                             random_deposit());
        end

        // With the table full, new cells are dropped while known cells still hit.
        for (int n = 0; n < 350; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_deposit(fresh_cell(), random_deposit());
            else if (pick < 55)
                send_deposit(prev_cell, random_deposit());
            else if (pick < 60)
                send_deposit(table_cells[0], random_deposit());
            else if (pick < 65)
                send_deposit(table_cells[TABLE_ENTRIES - 1], random_deposit());
            else
                send_deposit(table_cells[$urandom_range(0, TABLE_ENTRIES - 1)],
                             random_deposit());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
